[hdl/multi_button_debouncer_with_reset_hold_core_assert.svh]
// assertion macros shared by the debouncer rtl
`ifndef MULTI_BUTTON_DEBOUNCER_WITH_RESET_HOLD_CORE_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCER_WITH_RESET_HOLD_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define MBD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mbd_pkg.sv]
// shared types and constants of the multi-button debouncer
package mbd_pkg;

    // payload widths fixed by the item fields
    localparam int FIELD_W      = 4;
    localparam int DEB_W        = 8;
    localparam int HOLD_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    // default button count
    localparam int BUTTON_COUNT_DEF = 4;

    // register reset values
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 8'd20;
    localparam logic [HOLD_W-1:0]  HOLD_THR_RST   = 16'd2500;
    localparam logic [FIELD_W-1:0] COMBO_MASK_RST = 4'd5;
    localparam logic [FIELD_W-1:0] RECOV_MASK_RST = 4'd2;
    localparam logic               CHECK_EN_RST   = 1'b1;

    // hold counter top value
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_SAMPLES   = 3'd0,
        CFG_RESET_HOLD_SAMPLES = 3'd1,
        CFG_RESET_COMBO_MASK   = 3'd2,
        CFG_RECOVERY_MASK      = 3'd3,
        CFG_RESET_CHECK_ENABLE = 3'd4
    } cfg_index_t;

    // one result item, first field in the highest bits
    typedef struct packed {
        logic               idle;
        logic               recovery_mode;
        logic               reset_request;
        logic [FIELD_W-1:0] release_mask;
        logic [FIELD_W-1:0] press_mask;
        logic [FIELD_W-1:0] debounced_state;
    } result_t;

endpackage

[hdl/multi_button_debouncer_with_reset_hold_core.sv]
// multi-button debouncer with held-combination reset detection
//
// Each item on the s_axis channel is one sample tick carrying the raw pressed
// bits of the buttons in s_axis_tdata[3:0]. Every accepted item yields exactly
// one result item on m_axis: debounced state, press and release masks, the
// reset request, recovery mode and an idle flag.
// Configuration goes through cfg_wr_en / cfg_index / cfg_wdata, one register
// per write, taken at the clock edge; write only while no item is in flight.
// An accepted item is registered in the input register, processed
// combinationally and its result is registered in the output register.
// Throughput: one item per cycle unless m_axis_tready stalls; the per-button
// and hold counters update as the item moves to the output register.
// A stalled m_axis_tready holds the result; the input register still takes
// one more item, after which s_axis_tready drops until the output drains.
// Reset (aresetn low, synchronous) clears all counters and the debounced
// state, empties both registers and loads the register defaults.
module multi_button_debouncer_with_reset_hold_core #(
    parameter int BUTTON_COUNT = mbd_pkg::BUTTON_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample tick items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mbd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [3:0] raw_pressed, [7:4] zero
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mbd_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [3:0] debounced_state,
                                                           // [7:4] press_mask,
                                                           // [11:8] release_mask,
                                                           // [12] reset_request,
                                                           // [13] recovery_mode,
                                                           // [14] idle, [15] zero
);

    localparam int FW = mbd_pkg::FIELD_W;
    localparam int DW = mbd_pkg::DEB_W;
    localparam int HW = mbd_pkg::HOLD_W;

    // configuration registers
    logic [DW-1:0] debounce_reg;
    logic [HW-1:0] hold_thr_reg;
    logic [FW-1:0] combo_mask_reg;
    logic [FW-1:0] recov_mask_reg;
    logic          check_en_reg;

    // per-button and hold state
    logic [DW-1:0]           disagree_reg [BUTTON_COUNT];
    logic [DW-1:0]           disagree_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] stable_reg;
    logic [BUTTON_COUNT-1:0] stable_next;
    logic [HW-1:0]           hold_reg;
    logic [HW-1:0]           hold_next;

    // pipeline registers
    logic                    in_valid_reg;
    logic [FW-1:0]           in_raw_reg;
    logic                    out_valid_reg;
    mbd_pkg::result_t        out_reg;
    mbd_pkg::result_t        result_next;

    logic                    out_free;
    logic                    advance;
    logic [BUTTON_COUNT-1:0] raw_ext;
    logic [FW-1:0]           stable_view;
    logic [BUTTON_COUNT-1:0] pressed;
    logic [BUTTON_COUNT-1:0] released;
    logic [FW-1:0]           pressed_view;
    logic [FW-1:0]           released_view;
    logic                    busy;
    logic                    combo_held;

    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= mbd_pkg::DEBOUNCE_RST;
            hold_thr_reg   <= mbd_pkg::HOLD_THR_RST;
            combo_mask_reg <= mbd_pkg::COMBO_MASK_RST;
            recov_mask_reg <= mbd_pkg::RECOV_MASK_RST;
            check_en_reg   <= mbd_pkg::CHECK_EN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mbd_pkg::CFG_DEBOUNCE_SAMPLES:   debounce_reg   <= cfg_wdata[DW-1:0];
                mbd_pkg::CFG_RESET_HOLD_SAMPLES: hold_thr_reg   <= cfg_wdata[HW-1:0];
                mbd_pkg::CFG_RESET_COMBO_MASK:   combo_mask_reg <= cfg_wdata[FW-1:0];
                mbd_pkg::CFG_RECOVERY_MASK:      recov_mask_reg <= cfg_wdata[FW-1:0];
                mbd_pkg::CFG_RESET_CHECK_ENABLE: check_en_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // map between the four-bit fields and the button vector
    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_raw
        if (g < FW) begin : g_used
            assign raw_ext[g] = in_raw_reg[g];
        end else begin : g_none
            assign raw_ext[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < FW; g++) begin : g_view
        if (g < BUTTON_COUNT) begin : g_used
            assign stable_view[g]   = stable_next[g];
            assign pressed_view[g]  = pressed[g];
            assign released_view[g] = released[g];
        end else begin : g_none
            assign stable_view[g]   = 1'b0;
            assign pressed_view[g]  = 1'b0;
            assign released_view[g] = 1'b0;
        end
    end

    // per-button disagreement counters
    always_comb begin
        logic [DW-1:0] cnt_inc;
        busy        = 1'b0;
        stable_next = stable_reg;
        pressed     = '0;
        released    = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            cnt_inc          = disagree_reg[i] + DW'(1);
            disagree_next[i] = '0;
            if (raw_ext[i] != stable_reg[i]) begin
                busy = 1'b1;
                if (cnt_inc == debounce_reg) begin
                    stable_next[i] = raw_ext[i];
                    pressed[i]     = raw_ext[i];
                    released[i]    = !raw_ext[i];
                end else begin
                    disagree_next[i] = cnt_inc;
                end
            end
        end
    end

    // hold counter and result assembly
    always_comb begin
        combo_held = check_en_reg && ((stable_view & combo_mask_reg) == combo_mask_reg);
        if (!combo_held) begin
            hold_next = '0;
        end else if (hold_reg == mbd_pkg::HOLD_MAX) begin
            hold_next = hold_reg;
        end else begin
            hold_next = hold_reg + HW'(1);
        end
        result_next.debounced_state = stable_view;
        result_next.press_mask      = pressed_view;
        result_next.release_mask    = released_view;
        result_next.reset_request   = combo_held && (hold_next > hold_thr_reg);
        result_next.recovery_mode   = combo_held && (hold_next > hold_thr_reg)
                                      && ((stable_view & recov_mask_reg) != '0);
        result_next.idle            = !busy && !combo_held;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_raw_reg <= s_axis_tdata[FW-1:0];
        end
    end

    // state update and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            stable_reg    <= '0;
            hold_reg      <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                disagree_reg[i] <= '0;
            end
        end else begin
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                stable_reg <= stable_next;
                hold_reg   <= hold_next;
                for (int i = 0; i < BUTTON_COUNT; i++) begin
                    disagree_reg[i] <= disagree_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

`include "multi_button_debouncer_with_reset_hold_core_assert.svh"

    // a button cannot be pressed and released on the same tick
    `MBD_ASSERT_NOW(a_no_press_and_release, aclk, aresetn, m_axis_tvalid, (out_reg.press_mask & out_reg.release_mask) == '0, "press and release on one tick")
    // recovery mode only comes with a reset request
    `MBD_ASSERT_NOW(a_recovery_needs_request, aclk, aresetn, m_axis_tvalid && out_reg.recovery_mode, out_reg.reset_request, "recovery without reset request")
    // an idle tick reports no change
    `MBD_ASSERT_NOW(a_idle_no_change, aclk, aresetn, m_axis_tvalid && out_reg.idle, (out_reg.press_mask == '0) && (out_reg.release_mask == '0), "idle tick with change")
    // a pending request matches a running hold counter
    `MBD_ASSERT_NOW(a_request_has_hold, aclk, aresetn, m_axis_tvalid && out_reg.reset_request, hold_reg != '0, "reset request with cleared hold counter")

endmodule

[bench/testbench.sv]
// self-checking testbench for the multi-button debouncer core
module testbench;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam logic [mbd_pkg::CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd7;

    // scoreboard: tracks debouncer and hold state and checks every result item
    class button_scoreboard;
        logic [mbd_pkg::DEB_W-1:0]   flip_samples;
        logic [mbd_pkg::HOLD_W-1:0]  hold_limit;
        logic [mbd_pkg::FIELD_W-1:0] combo_mask;
        logic [mbd_pkg::FIELD_W-1:0] recovery_mask;
        logic                        check_en;
        logic [mbd_pkg::DEB_W-1:0]   disagree[mbd_pkg::BUTTON_COUNT_DEF];
        logic [mbd_pkg::FIELD_W-1:0] debounced;
        logic [mbd_pkg::HOLD_W-1:0]  hold_cnt;
        mbd_pkg::result_t            awaited_q[$];
        int                          fail_count;
        int                          seen_count;

        function new();
            flip_samples  = mbd_pkg::DEBOUNCE_RST;
            hold_limit    = mbd_pkg::HOLD_THR_RST;
            combo_mask    = mbd_pkg::COMBO_MASK_RST;
            recovery_mask = mbd_pkg::RECOV_MASK_RST;
            check_en      = mbd_pkg::CHECK_EN_RST;
            foreach (disagree[i]) disagree[i] = '0;
            debounced  = '0;
            hold_cnt   = '0;
            fail_count = 0;
            seen_count = 0;
        endfunction

        function void write_reg(logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                                logic [mbd_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                mbd_pkg::CFG_DEBOUNCE_SAMPLES:   flip_samples  = val[mbd_pkg::DEB_W-1:0];
                mbd_pkg::CFG_RESET_HOLD_SAMPLES: hold_limit    = val[mbd_pkg::HOLD_W-1:0];
                mbd_pkg::CFG_RESET_COMBO_MASK:   combo_mask    = val[mbd_pkg::FIELD_W-1:0];
                mbd_pkg::CFG_RECOVERY_MASK:      recovery_mask = val[mbd_pkg::FIELD_W-1:0];
                mbd_pkg::CFG_RESET_CHECK_ENABLE: check_en      = val[0];
                default: ;
            endcase
        endfunction

        // one accepted sample tick: advance the counters and queue its result
        function void note_tick(logic [mbd_pkg::FIELD_W-1:0] raw);
            mbd_pkg::result_t r;
            logic             busy;
            logic             held;
            r    = '0;
            busy = 1'b0;
            held = 1'b0;
            for (int i = 0; i < mbd_pkg::BUTTON_COUNT_DEF; i++) begin
                if (raw[i] == debounced[i]) begin
                    disagree[i] = '0;
                end else begin
                    busy        = 1'b1;
                    disagree[i] = disagree[i] + 1'b1;
                    if (disagree[i] == flip_samples) begin
                        disagree[i]  = '0;
                        debounced[i] = raw[i];
                        if (raw[i]) r.press_mask[i] = 1'b1;
                        else r.release_mask[i] = 1'b1;
                    end
                end
            end
            // hold counter runs only while detection is on and the combination is held
            if (check_en) begin
                held = ((debounced & combo_mask) == combo_mask);
                if (held) begin
                    if (hold_cnt != mbd_pkg::HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
                    if (hold_cnt > hold_limit) begin
                        r.reset_request = 1'b1;
                        r.recovery_mode = |(debounced & recovery_mask);
                    end
                end else begin
                    hold_cnt = '0;
                end
            end else begin
                hold_cnt = '0;
            end
            r.debounced_state = debounced;
            r.idle            = !busy && !held;
            awaited_q.push_back(r);
        endfunction

        function string show(mbd_pkg::result_t r);
            return $sformatf("state %h press %h release %h req %b recov %b idle %b",
                r.debounced_state, r.press_mask, r.release_mask,
                r.reset_request, r.recovery_mode, r.idle);
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= 10) $display("%s", msg);
        endfunction

        // compare one result item with the oldest pending tick
        function void check_result(logic [mbd_pkg::M_TDATA_W-1:0] tdata);
            mbd_pkg::result_t got;
            mbd_pkg::result_t want;
            string            bad;
            got = tdata[$bits(mbd_pkg::result_t)-1:0];
            seen_count++;
            if (awaited_q.size() == 0) begin
                flag($sformatf("result %0d with no tick pending: %s", seen_count, show(got)));
                return;
            end
            want = awaited_q.pop_front();
            bad  = "";
            if (got.debounced_state !== want.debounced_state) bad = {bad, " debounced_state"};
            if (got.press_mask !== want.press_mask)           bad = {bad, " press_mask"};
            if (got.release_mask !== want.release_mask)       bad = {bad, " release_mask"};
            if (got.reset_request !== want.reset_request)     bad = {bad, " reset_request"};
            if (got.recovery_mode !== want.recovery_mode)     bad = {bad, " recovery_mode"};
            if (got.idle !== want.idle)                       bad = {bad, " idle"};
            if (bad != "")
                flag($sformatf("result %0d mismatch in%s: expected %s, got %s",
                    seen_count, bad, show(want), show(got)));
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mbd_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [mbd_pkg::S_TDATA_W-1:0]  s_axis_tdata;   // [3:0] raw_pressed, [7:4] zero
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mbd_pkg::M_TDATA_W-1:0]  m_axis_tdata;   // [3:0] debounced_state, [7:4] press_mask,
                                                    // [11:8] release_mask, [12] reset_request,
                                                    // [13] recovery_mode, [14] idle, [15] zero

    button_scoreboard board = new();
    bit fast_mode;
    bit tx_quiet;
    bit rx_quiet;
    int cycle_count;

    multi_button_debouncer_with_reset_hold_core #(
        .BUTTON_COUNT(mbd_pkg::BUTTON_COUNT_DEF)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random back-pressure, checks each accepted item
    initial begin
        int stall_left;
        int cyc;
        m_axis_tready <= 1'b0;
        stall_left = 0;
        cyc        = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            cyc++;
            if (cyc % 300 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            if (fast_mode || rx_quiet) stall_left = 0;
            else if (stall_left > 0) stall_left--;
            else if (m_axis_tready) stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic send_tick(input logic [mbd_pkg::FIELD_W-1:0] raw);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mbd_pkg::S_TDATA_W-mbd_pkg::FIELD_W){1'b0}}, raw};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_tick(raw);
        gap = (fast_mode || tx_quiet) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 15));
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the input until every pending result has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (board.awaited_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbd_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // full register set, with junk above each register's width
    task automatic apply_setting(input logic [mbd_pkg::DEB_W-1:0] deb,
                                 input logic [mbd_pkg::HOLD_W-1:0] thr,
                                 input logic [mbd_pkg::FIELD_W-1:0] combo,
                                 input logic [mbd_pkg::FIELD_W-1:0] recov, input logic en);
        logic [mbd_pkg::CFG_DATA_W-1:0] junk;
        junk = 16'($urandom);
        write_reg(mbd_pkg::CFG_DEBOUNCE_SAMPLES, {junk[15:8], deb});
        write_reg(mbd_pkg::CFG_RESET_HOLD_SAMPLES, thr);
        write_reg(mbd_pkg::CFG_RESET_COMBO_MASK, {junk[15:4], combo});
        write_reg(mbd_pkg::CFG_RECOVERY_MASK, {junk[11:0], recov});
        write_reg(mbd_pkg::CFG_RESET_CHECK_ENABLE, {junk[15:1], en});
        write_reg(CFG_NO_REGISTER, junk);
    endtask

    // random press runs with bounce noise, run lengths around the debounce count
    task automatic run_phase(input int n_items);
        logic [mbd_pkg::FIELD_W-1:0] target;
        logic [mbd_pkg::FIELD_W-1:0] raw;
        int run_left;
        int deb_eff;
        int noise_div;
        deb_eff   = (board.flip_samples == 0) ? 256 : board.flip_samples;
        noise_div = (deb_eff > 16) ? 1000 : 8;
        target    = '0;
        run_left  = 0;
        tx_quiet  = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                target = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 1)) target |= board.combo_mask;
                run_left = $urandom_range(1, 2 * deb_eff + 2);
            end
            run_left--;
            raw = target;
            if ($urandom_range(1, noise_div) == 1) raw ^= 4'(1 << $urandom_range(0, 3));
            if (k % 64 == 63) tx_quiet = ($urandom_range(0, 3) == 0);
            send_tick(raw);
            if ($urandom_range(0, 199) == 0) wait_drain();
        end
        wait_drain();
    endtask

    // stimulus
    initial begin
        logic [mbd_pkg::DEB_W-1:0]   deb;
        logic [mbd_pkg::HOLD_W-1:0]  thr;
        logic [mbd_pkg::FIELD_W-1:0] combo;
        logic [mbd_pkg::FIELD_W-1:0] recov;
        logic                        en;
        int                          r;
        int                          n;

        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        fast_mode = 1'b0;
        tx_quiet  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults after reset
        send_tick(4'h0);
        send_tick(4'hF);
        send_tick(4'h0);
        wait_drain();

        // single-sample flips, immediate reset request and recovery select
        apply_setting(8'd1, 16'd0, 4'h5, 4'h2, 1'b1);
        send_tick(4'h0);
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'h5);
        send_tick(4'h5);
        send_tick(4'hA);
        send_tick(4'h0);
        wait_drain();

        // bouncing input, empty combination mask, several recovery bits
        apply_setting(8'd3, 16'd2, 4'h0, 4'h3, 1'b1);
        send_tick(4'h1);
        send_tick(4'h0);
        send_tick(4'h1);
        send_tick(4'h1);
        send_tick(4'h1);
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'h0);
        wait_drain();

        // detection switched off
        apply_setting(8'd2, 16'd1, 4'hF, 4'h0, 1'b0);
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'h0);
        wait_drain();

        // zero sample count: counter wraps, flip after 256 samples
        apply_setting(8'd0, 16'd65534, 4'hF, 4'h0, 1'b1);
        repeat (257) send_tick(4'hF);
        repeat (257) send_tick(4'h0);
        wait_drain();

        // random settings
        for (int p = 0; p < 10; p++) begin
            r = $urandom_range(0, 9);
            deb = (r == 0) ? 8'd1 : 8'($urandom_range(1, 6));
            r = $urandom_range(0, 9);
            case (r)
                0: thr = 16'd0;
                1: thr = 16'd1;
                2: thr = 16'd65534;
                3: thr = 16'd65535;
                default: thr = 16'($urandom_range(2, 30));
            endcase
            r = $urandom_range(0, 9);
            combo = (r == 0) ? 4'h0 : (r == 1) ? 4'hF : 4'($urandom_range(0, 15));
            r = $urandom_range(0, 9);
            recov = (r == 0) ? 4'h0 : (r == 1) ? 4'hF : 4'($urandom_range(0, 15));
            en = ($urandom_range(0, 4) != 0);
            n  = 110;
            if (p == 1) begin
                deb = 8'd255;
                n   = 300;
            end
            if (p == 2) en = 1'b0;
            if (p == 3) begin
                combo = 4'h0;
                recov = 4'hF;
            end
            apply_setting(deb, thr, combo, recov, en);
            run_phase(n);
        end

        // threshold at the counter top value: no request ever
        fast_mode = 1'b1;
        apply_setting(8'd1, 16'd65535, 4'h0, 4'hF, 1'b1);
        repeat (40) send_tick(4'($urandom_range(0, 15)));
        wait_drain();
        fast_mode = 1'b0;

        repeat (8) @(posedge aclk);
        if (board.awaited_q.size() != 0)
            board.flag($sformatf("%0d results never arrived", board.awaited_q.size()));
        if (board.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/mbd_pkg.sv
hdl/multi_button_debouncer_with_reset_hold_core.sv
bench/testbench.sv
